>>> sv/cssc_pkg.sv
// ----------------------------------------------------------------------------
// cssc_pkg: shared types and constants
// character codes, scan mode codes and result word layout for the
// comment strip / space collapse unit
// ----------------------------------------------------------------------------
package cssc_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned MaxResults = 3;
   localparam int unsigned CountWidth = $clog2(MaxResults + 1);

   localparam logic [CharWidth-1:0] CharSlash = 8'h2F;
   localparam logic [CharWidth-1:0] CharStar  = 8'h2A;
   localparam logic [CharWidth-1:0] CharNl    = 8'h0A;
   localparam logic [CharWidth-1:0] CharSpace = 8'h20;
   localparam logic [CharWidth-1:0] CharTab   = 8'h09;
   localparam logic [CharWidth-1:0] CharCr    = 8'h0D;
   localparam logic [CharWidth-1:0] CharNul   = 8'h00;

   // scan mode, one-hot
   typedef enum logic [3:0] {
      MODE_NORMAL = 4'b0001,
      MODE_LINE   = 4'b0010,
      MODE_BLOCK  = 4'b0100,
      MODE_STAR   = 4'b1000
   } mode_type;

   // one result word
   typedef struct packed {
      logic [CharWidth-1:0] out_char;
      logic                 has_char;
      logic                 run_last;
      logic                 text_end;
   } result_type;

   // all result words caused by one input word
   typedef struct packed {
      logic [CountWidth-1:0]         count;
      result_type [MaxResults-1:0]   item;
   } bundle_type;

   function automatic logic is_white(input logic [CharWidth-1:0] c);
      return ((c >= CharTab) && (c <= CharCr)) || (c == CharSpace);
   endfunction

endpackage

>>> sv/cssc_scan.sv
// ----------------------------------------------------------------------------
// cssc_scan: comment scanner and whitespace collapse
// holds the scan state and forms the result words of one input word
// ----------------------------------------------------------------------------
module cssc_scan (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              take,
   input  logic [cssc_pkg::CharWidth-1:0]    text_byte,
   input  logic                              final_byte,
   output cssc_pkg::bundle_type              bundle
);

   cssc_pkg::mode_type mode_ff, mode_in;
   logic held_ff, held_in;
   logic any_ff, any_in;
   logic lws_ff, lws_in;

   logic pre_slash;
   logic plain;
   logic any_t;
   logic lws_t;
   logic [cssc_pkg::CountWidth-1:0] n;
   cssc_pkg::bundle_type b;

   always_comb begin
      mode_in   = mode_ff;
      held_in   = held_ff;
      pre_slash = 1'b0;
      plain     = 1'b0;
      n         = '0;
      b         = '0;

      case (mode_ff)
         cssc_pkg::MODE_LINE: begin
            if (text_byte == cssc_pkg::CharNl) mode_in = cssc_pkg::MODE_NORMAL;
         end
         cssc_pkg::MODE_BLOCK: begin
            if (text_byte == cssc_pkg::CharStar) mode_in = cssc_pkg::MODE_STAR;
         end
         cssc_pkg::MODE_STAR: begin
            if (text_byte == cssc_pkg::CharSlash) begin
               mode_in = cssc_pkg::MODE_NORMAL;
            end else if (text_byte != cssc_pkg::CharStar) begin
               mode_in = cssc_pkg::MODE_BLOCK;
            end
         end
         default: begin
            if (held_ff) begin
               held_in = 1'b0;
               if (text_byte == cssc_pkg::CharSlash) begin
                  mode_in = cssc_pkg::MODE_LINE;
               end else if (text_byte == cssc_pkg::CharStar) begin
                  mode_in = cssc_pkg::MODE_BLOCK;
               end else begin
                  pre_slash = 1'b1;
                  plain     = 1'b1;
               end
            end else if ((text_byte == cssc_pkg::CharSlash) && !final_byte) begin
               held_in = 1'b1;
            end else begin
               plain = 1'b1;
            end
         end
      endcase

      any_t = any_ff;
      lws_t = lws_ff;

      // held slash goes out ahead of this byte
      if (pre_slash) begin
         b.item[n].out_char = cssc_pkg::CharSlash;
         b.item[n].has_char = 1'b1;
         n     = n + 1'b1;
         any_t = 1'b1;
         lws_t = 1'b0;
      end

      if (plain) begin
         if (cssc_pkg::is_white(text_byte)) begin
            if (any_t && !lws_t) begin
               b.item[n].out_char = cssc_pkg::CharSpace;
               b.item[n].has_char = 1'b1;
               n     = n + 1'b1;
               lws_t = 1'b1;
            end
         end else begin
            b.item[n].out_char = text_byte;
            b.item[n].has_char = 1'b1;
            n     = n + 1'b1;
            any_t = 1'b1;
            lws_t = 1'b0;
         end
      end

      any_in = any_t;
      lws_in = lws_t;

      // end marker, then back to reset state
      if (final_byte) begin
         b.item[n].out_char = cssc_pkg::CharNul;
         b.item[n].text_end = 1'b1;
         n       = n + 1'b1;
         mode_in = cssc_pkg::MODE_NORMAL;
         held_in = 1'b0;
         any_in  = 1'b0;
         lws_in  = 1'b0;
      end

      if (n != '0) b.item[n - 1'b1].run_last = 1'b1;
      b.count = n;
      bundle  = b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= cssc_pkg::MODE_NORMAL;
         held_ff <= 1'b0;
         any_ff  <= 1'b0;
         lws_ff  <= 1'b0;
      end else if (take) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
         any_ff  <= any_in;
         lws_ff  <= lws_in;
      end
   end

endmodule

>>> sv/cssc_rbuf.sv
// ----------------------------------------------------------------------------
// cssc_rbuf: result buffer
// holds up to three result words and, while out_ready is high, hands them out one per cycle
// ----------------------------------------------------------------------------
module cssc_rbuf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  cssc_pkg::bundle_type  bundle,
   input  logic                  out_ready,
   output logic                  out_valid,
   output cssc_pkg::result_type  head,
   output logic                  can_load
);

   cssc_pkg::result_type [cssc_pkg::MaxResults-1:0] q_ff, q_in;
   logic [cssc_pkg::CountWidth-1:0] cnt_ff, cnt_in;
   logic pop;

   assign out_valid = (cnt_ff != '0);
   assign head      = q_ff[0];
   assign pop       = out_valid && out_ready;
   // new words fit once the buffer is empty after this cycle
   assign can_load  = (cnt_ff == '0) ||
                      ((cnt_ff == {{(cssc_pkg::CountWidth-1){1'b0}}, 1'b1}) && out_ready);

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (load) begin
         q_in   = bundle.item;
         cnt_in = bundle.count;
      end else if (pop) begin
         for (int i = 0; i < cssc_pkg::MaxResults - 1; i++) q_in[i] = q_ff[i+1];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule

>>> sv/comment_strip_space_collapse_unit.sv
// ----------------------------------------------------------------------------
// comment_strip_space_collapse_unit: comment stripper with space collapse
// removes // and /* */ comments from a byte stream and folds whitespace
// runs into single spaces
// ----------------------------------------------------------------------------
//  channel   direction  ports                                         handshake
//  req       in         req_text_byte, req_final_byte                 req_valid/req_ready
//  rsp       out        rsp_out_char, rsp_has_char, rsp_run_last,     rsp_valid/rsp_ready
//                       rsp_text_end
//
//  one input word per cycle while req_ready is high; each word makes zero to three
//  result words; the result buffer drains one word per cycle while rsp_ready is high,
//  so a word with two or three results holds req_ready low until its last one is taken
//  req_ready = buffer empty, or one word left that is taken this cycle
//  reset is synchronous: scan state back to normal text, buffer emptied
//  a stall on rsp only backs up into req once the buffer holds a word
// ----------------------------------------------------------------------------
module comment_strip_space_collapse_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cssc_pkg::CharWidth-1:0]  req_text_byte,
   input  logic                            req_final_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cssc_pkg::CharWidth-1:0]  rsp_out_char,
   output logic                            rsp_has_char,
   output logic                            rsp_run_last,
   output logic                            rsp_text_end
);

   logic                  take;     // input word accepted this cycle
   cssc_pkg::bundle_type  bundle;   // result words of the current input word
   cssc_pkg::result_type  head;     // result word at the buffer head

   assign take = req_valid && req_ready;

   // scanner: state only advances on an accepted word
   cssc_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .text_byte  (req_text_byte),
      .final_byte (req_final_byte),
      .bundle     (bundle)
   );

   // result buffer doubles as the output register
   cssc_rbuf u_rbuf (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .bundle    (bundle),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid),
      .head      (head),
      .can_load  (req_ready)
   );

   assign rsp_out_char = head.out_char;
   assign rsp_has_char = head.has_char;
   assign rsp_run_last = head.run_last;
   assign rsp_text_end = head.text_end;

   // end marker carries no character and closes its input word
   a_end_marker_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_text_end) |-> (!rsp_has_char && rsp_run_last))
      else $error("end marker with character or not last");

   // remaining words of one input word follow with no gap
   a_run_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_run_last) |=> rsp_valid)
      else $error("gap inside the results of one input word");

   // the last byte of a text always leaves a result pending
   a_final_gives_result: assert property (@(posedge clock) disable iff (reset)
      (take && req_final_byte) |=> rsp_valid)
      else $error("no result after final byte");

   // no input word is taken while earlier results would be overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_run_last) |-> !req_ready)
      else $error("input accepted over pending results");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the comment strip / space collapse unit
// sends short source texts one word at a time and checks every result word
// against a cycle-free model of the scanner, with random stalls on both sides
// ----------------------------------------------------------------------------
module tb_top;
   import cssc_pkg::*;

   localparam int CycleLimit  = 200_000;
   localparam int DrainCycles = 20;
   localparam int PhaseWords  = 80;
   localparam int ShownErrors = 10;

   // clock, reset and block ports; every input is known from time zero
   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic [CharWidth-1:0] req_text_byte  = '0;
   logic                 req_final_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [CharWidth-1:0] rsp_out_char;
   logic                 rsp_has_char;
   logic                 rsp_run_last;
   logic                 rsp_text_end;

   // idle rates in percent, changed per test phase
   int sender_idle   = 0;
   int receiver_idle = 0;

   int cycle_count   = 0;
   int fail_count    = 0;

   // scanner model state
   mode_type scan_mode   = MODE_NORMAL;
   logic     slash_held  = 1'b0;
   logic     char_seen   = 1'b0;
   logic     space_last  = 1'b0;

   // result words still owed by the block, oldest first
   result_type pending_results[$];

   // text being sent by the current test
   logic [CharWidth-1:0] text_buf[$];

   comment_strip_space_collapse_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_text_byte  (req_text_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_has_char   (rsp_has_char),
      .rsp_run_last   (rsp_run_last),
      .rsp_text_end   (rsp_text_end)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle);
   end

   // ------------------------------------------------------------------------
   // scanner model
   // ------------------------------------------------------------------------

   // tab, newline, vertical tab, form feed, carriage return or space
   function automatic logic blank_byte(input logic [CharWidth-1:0] c);
      return (c == CharSpace) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic void owe_result(input logic [CharWidth-1:0] c, input logic has,
                                      input logic text_done);
      result_type r;
      r.out_char = c;
      r.has_char = has;
      r.run_last = 1'b0;
      r.text_end = text_done;
      pending_results.insert(pending_results.size(), r);
   endfunction

   // one character into normal text: whitespace folds, leading blanks vanish
   function automatic void fold_char(input logic [CharWidth-1:0] c);
      if (blank_byte(c)) begin
         if (char_seen && !space_last) begin
            owe_result(CharSpace, 1'b1, 1'b0);
            space_last = 1'b1;
         end
      end else begin
         owe_result(c, 1'b1, 1'b0);
         char_seen  = 1'b1;
         space_last = 1'b0;
      end
   endfunction

   // work out the result words of one accepted word
   function automatic void predict_word(input logic [CharWidth-1:0] c, input logic fin);
      int         first_new;
      int         last_idx;
      result_type r;
      first_new = pending_results.size();
      case (scan_mode)
         MODE_LINE: begin
            if (c == CharNl) scan_mode = MODE_NORMAL;
         end
         MODE_BLOCK: begin
            if (c == CharStar) scan_mode = MODE_STAR;
         end
         MODE_STAR: begin
            if (c == CharSlash) scan_mode = MODE_NORMAL;
            else if (c != CharStar) scan_mode = MODE_BLOCK;
         end
         default: begin
            if (slash_held) begin
               slash_held = 1'b0;
               if (c == CharSlash) scan_mode = MODE_LINE;
               else if (c == CharStar) scan_mode = MODE_BLOCK;
               else begin
                  // slash was plain text after all, it goes out first
                  fold_char(CharSlash);
                  fold_char(c);
               end
            end else if (c == CharSlash && !fin) begin
               slash_held = 1'b1;
            end else begin
               fold_char(c);
            end
         end
      endcase
      // end of text: marker word, then everything back to the reset state
      if (fin) begin
         owe_result(CharNul, 1'b0, 1'b1);
         scan_mode  = MODE_NORMAL;
         slash_held = 1'b0;
         char_seen  = 1'b0;
         space_last = 1'b0;
      end
      if (pending_results.size() > first_new) begin
         last_idx = pending_results.size() - 1;
         r = pending_results[last_idx];
         r.run_last = 1'b1;
         pending_results[last_idx] = r;
      end
   endfunction

   // ------------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            fail_count = fail_count + 1;
            if (fail_count <= ShownErrors)
               $display("unexpected word: char %h has %b last %b end %b",
                        rsp_out_char, rsp_has_char, rsp_run_last, rsp_text_end);
         end else begin
            want = pending_results.pop_front();
            if (rsp_out_char !== want.out_char || rsp_has_char !== want.has_char ||
                rsp_run_last !== want.run_last || rsp_text_end !== want.text_end) begin
               fail_count = fail_count + 1;
               if (fail_count <= ShownErrors)
                  $display("mismatch: char %h/%h has %b/%b last %b/%b end %b/%b (exp/act)",
                           want.out_char, rsp_out_char, want.has_char, rsp_has_char,
                           want.run_last, rsp_run_last, want.text_end, rsp_text_end);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------

   // one word: optional idle gap, then valid held until the handshake
   task automatic send_word(input logic [CharWidth-1:0] c, input logic fin);
      while ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_text_byte  <= c;
      req_final_byte <= fin;
      do @(posedge clock); while (!req_ready);
      predict_word(c, fin);
   endtask

   // whole text buffer, final flag on the last word
   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++)
         send_word(text_buf[i], i == text_buf.size() - 1);
   endtask

   task automatic test_byte_extremes();
      text_buf = '{CharNul, 8'hFF};
      send_text();
   endtask

   // leading blanks drop, mixed run folds, trailing space on the last word stays
   task automatic test_space_folding();
      text_buf = '{CharSpace, CharTab, 8'h61, CharCr, CharNl, 8'h62, CharSpace};
      send_text();
   endtask

   // line comment closed by newline, then a slash as the last word
   task automatic test_line_comment();
      text_buf = '{CharSlash, CharSlash, 8'h71, CharNl, CharSlash};
      send_text();
   endtask

   // opening star cannot close, star run before slash closes,
   // held slash then plain char on the last word gives three words
   task automatic test_block_comment();
      text_buf = '{CharSlash, CharStar, CharSlash, CharStar, CharStar, CharSlash,
                   8'h7A, CharSlash, 8'h63};
      send_text();
   endtask

   // append one byte to the text being built
   function automatic void add_byte(input logic [CharWidth-1:0] c);
      text_buf.insert(text_buf.size(), c);
   endfunction

   // random byte in lo..hi
   function automatic logic [CharWidth-1:0] rand_byte(input int lo, input int hi);
      int v;
      v = $urandom_range(hi, lo);
      return v[CharWidth-1:0];
   endfunction

   function automatic logic [CharWidth-1:0] pick_blank();
      int k;
      k = $urandom_range(9, 14);
      return (k == 14) ? CharSpace : k[CharWidth-1:0];
   endfunction

   // fill text_buf with a random mix of words, blanks, comments and junk
   task automatic build_text();
      int tokens;
      text_buf.delete();
      tokens = $urandom_range(1, 8);
      repeat (tokens) begin
         case ($urandom_range(9))
            0, 1: repeat ($urandom_range(1, 4)) add_byte(rand_byte(8'h30, 8'h7A));
            2:    repeat ($urandom_range(1, 3)) add_byte(pick_blank());
            3: begin
               add_byte(CharSlash);
               add_byte(CharSlash);
               repeat ($urandom_range(0, 4)) add_byte(rand_byte(8'h20, 8'hFF));
               // now and then left open to the end of the text
               if ($urandom_range(4) != 0) add_byte(CharNl);
            end
            4: begin
               add_byte(CharSlash);
               add_byte(CharStar);
               repeat ($urandom_range(0, 4)) begin
                  case ($urandom_range(3))
                     0:       add_byte(CharStar);
                     1:       add_byte(CharSlash);
                     default: add_byte(rand_byte(0, 255));
                  endcase
               end
               if ($urandom_range(4) != 0) begin
                  add_byte(CharStar);
                  add_byte(CharSlash);
               end
            end
            5:       add_byte(CharSlash);
            6:       add_byte(CharStar);
            7:       add_byte(rand_byte(0, 255));
            8:       add_byte(rand_byte(8'h80, 8'hFF));
            default: add_byte(rand_byte(8'h00, 8'h1F));
         endcase
      end
   endtask

   task automatic test_random_text(input int word_goal, input int send_pct, input int recv_pct);
      int sent;
      sender_idle   = send_pct;
      receiver_idle = recv_pct;
      sent = 0;
      while (sent < word_goal) begin
         build_text();
         send_text();
         sent = sent + text_buf.size();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      sender_idle   = 28;
      receiver_idle = 57;
      test_byte_extremes();
      test_space_folding();
      test_line_comment();
      test_block_comment();

      test_random_text(PhaseWords, 28, 57);
      test_random_text(PhaseWords, 57, 28);
      test_random_text(PhaseWords, 0, 0);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
